// File: hw/rtl/vmr_pkg.sv
package vmr_pkg;

  localparam int MaxRegions = 64;
  localparam int NumSpaces  = 8;

  localparam logic [1:0] FuncMap   = 2'd0;
  localparam logic [1:0] FuncFork  = 2'd1;
  localparam logic [1:0] FuncFault = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StInvalid  = 2'd1;
  localparam logic [1:0] StGuard    = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  localparam int FlWrite  = 1;
  localparam int FlGuard  = 2;
  localparam int FlDemand = 3;
  localparam int FlCow    = 4;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] limit;
    logic [4:0]  flags;
    logic [2:0]  space;
  } entry_t;

endpackage

// File: hw/rtl/vmr_cell.sv
module vmr_cell (
  input  logic            clk_i,
  input  logic            push_i,
  input  vmr_pkg::entry_t entry_i,
  input  logic            load_i,
  input  logic            shift_i,
  input  vmr_pkg::entry_t shadow_i,
  input  logic            wr_flags_i,
  input  logic [4:0]      flags_i,
  output vmr_pkg::entry_t entry_o,
  output vmr_pkg::entry_t shadow_o
);

  vmr_pkg::entry_t entry_q;
  vmr_pkg::entry_t shadow_q;

  // main stack: newest entry sits in cell 0
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q <= entry_i;
    end else if (wr_flags_i) begin
      entry_q.flags <= flags_i;
    end
  end

  // scan copy walks toward cell 0
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      shadow_q <= entry_q;
    end else if (shift_i) begin
      shadow_q <= shadow_i;
    end
  end

  assign entry_o  = entry_q;
  assign shadow_o = shadow_q;

endmodule

// File: hw/rtl/vm_region_table_cow_fault_top.sv
// Region table with copy-on-write fork and fault lookup. An operation is taken
// when start is high and busy is low; its status appears on status_o for one
// cycle with done_o high, and must be captured then. Fork and fault copy the
// table into a scan chain and walk it one entry per cycle, newest first, over
// the used entries, at most MAX_REGIONS; a fault stops at the first hit.
module vm_region_table_cow_fault_top #(
  parameter int MAX_REGIONS = vmr_pkg::MaxRegions
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [2:0]  space_i,
  input  logic [2:0]  source_space_i,
  input  logic [63:0] address_i,
  input  logic [63:0] length_i,
  input  logic [4:0]  region_bits_i,
  output logic        done_o,
  output logic [1:0]  status_o
);

  localparam int CntW = $clog2(MAX_REGIONS + 1);
  localparam int IdxW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FORK,
    S_FAULT
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  used_q, step_q, snap_q;
  logic             done_q;
  logic [1:0]       status_q;
  logic [2:0]       dst_q, src_q;
  logic [63:0]      addr_q;

  vmr_pkg::entry_t  entries [MAX_REGIONS];
  vmr_pkg::entry_t  shadows [MAX_REGIONS];
  vmr_pkg::entry_t  push_data, head;

  logic            accept, sp_bad, src_bad, full, scan_end, hit;
  logic            push_en, load_en, shift_en, wr_en;
  logic [4:0]      wr_flags, copy_flags;

  assign accept   = start && !busy;
  assign sp_bad   = int'(space_i) >= vmr_pkg::NumSpaces;
  assign src_bad  = int'(source_space_i) >= vmr_pkg::NumSpaces;
  assign full     = used_q == CntW'(MAX_REGIONS);
  assign head     = shadows[0];
  assign scan_end = step_q == snap_q;
  assign hit      = (head.space == dst_q) && (addr_q >= head.base) && (addr_q < head.limit);

  always_comb begin
    copy_flags = head.flags;
    if (head.flags[vmr_pkg::FlWrite]) begin
      copy_flags[vmr_pkg::FlWrite] = 1'b0;
      copy_flags[vmr_pkg::FlCow]   = 1'b1;
    end
    wr_flags = head.flags;
    wr_flags[vmr_pkg::FlWrite] = 1'b1;
    wr_flags[vmr_pkg::FlCow]   = 1'b0;
  end

  always_comb begin
    push_en   = 1'b0;
    load_en   = 1'b0;
    shift_en  = 1'b0;
    wr_en     = 1'b0;
    push_data = '{base: address_i, limit: address_i + length_i,
                  flags: region_bits_i, space: space_i};
    case (state_q)
      S_IDLE: begin
        if (accept && !sp_bad) begin
          case (func_i)
            vmr_pkg::FuncMap:   push_en = (length_i != 64'd0) && !full;
            vmr_pkg::FuncFork:  load_en = !src_bad;
            vmr_pkg::FuncFault: load_en = 1'b1;
            default:            load_en = 1'b0;
          endcase
        end
      end
      S_FORK: begin
        push_data = '{base: head.base, limit: head.limit, flags: copy_flags, space: dst_q};
        if (!scan_end) begin
          shift_en = 1'b1;
          push_en  = (head.space == src_q) && !full;
        end
      end
      S_FAULT: begin
        if (!scan_end) begin
          if (hit) begin
            wr_en = !head.flags[vmr_pkg::FlGuard] && !head.flags[vmr_pkg::FlDemand] &&
                    head.flags[vmr_pkg::FlCow];
          end else begin
            shift_en = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    vmr_pkg::entry_t ein, sin;
    if (i == 0) begin : g_first
      assign ein = push_data;
    end else begin : g_mid
      assign ein = entries[i-1];
    end
    if (i == MAX_REGIONS - 1) begin : g_last
      assign sin = '0;
    end else begin : g_rest
      assign sin = shadows[i+1];
    end
    vmr_cell u_cell (
      .clk_i      (clk_i),
      .push_i     (push_en),
      .entry_i    (ein),
      .load_i     (load_en),
      .shift_i    (shift_en),
      .shadow_i   (sin),
      .wr_flags_i (wr_en && (step_q[IdxW-1:0] == IdxW'(i))),
      .flags_i    (wr_flags),
      .entry_o    (entries[i]),
      .shadow_o   (shadows[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      step_q   <= '0;
      snap_q   <= '0;
      done_q   <= 1'b0;
      status_q <= vmr_pkg::StOk;
      dst_q    <= '0;
      src_q    <= '0;
      addr_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (push_en) begin
        used_q <= used_q + CntW'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            dst_q  <= space_i;
            src_q  <= source_space_i;
            addr_q <= address_i;
            step_q <= '0;
            snap_q <= used_q;
            if (load_en) begin
              state_q <= (func_i == vmr_pkg::FuncFork) ? S_FORK : S_FAULT;
            end else begin
              done_q   <= 1'b1;
              status_q <= push_en ? vmr_pkg::StOk : vmr_pkg::StInvalid;
            end
          end
        end
        S_FORK: begin
          if (scan_end) begin
            state_q  <= S_IDLE;
            done_q   <= 1'b1;
            status_q <= vmr_pkg::StOk;
          end else begin
            step_q <= step_q + CntW'(1);
          end
        end
        S_FAULT: begin
          if (scan_end) begin
            state_q  <= S_IDLE;
            done_q   <= 1'b1;
            status_q <= vmr_pkg::StNotFound;
          end else if (hit) begin
            state_q  <= S_IDLE;
            done_q   <= 1'b1;
            status_q <= head.flags[vmr_pkg::FlGuard] ? vmr_pkg::StGuard : vmr_pkg::StOk;
          end else begin
            step_q <= step_q + CntW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy     = state_q != S_IDLE;
  assign done_o   = done_q;
  assign status_o = status_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(MAX_REGIONS)) else $error("region count overflow");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while scanning");

  a_rise_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !done_o) else $error("result on scan start");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> step_q <= snap_q) else $error("scan ran past snapshot");

endmodule

// File: dv/vm_region_table_cow_fault_top_tb.sv
`timescale 1ns / 1ps

module vm_region_table_cow_fault_top_tb;

  class status_board;
    logic [1:0] pending_status[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(logic [1:0] st);
      pending_status.push_back(st);
    endfunction

    function void check_status(logic [1:0] got);
      logic [1:0] want;
      if (pending_status.size() == 0) begin
        $error("status: unexpected transfer, actual %0d", got);
        errors++;
      end else begin
        want = pending_status.pop_front();
        if (want !== got) begin
          $error("status: expected %0d actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  func_i;
  logic [2:0]  space_i;
  logic [2:0]  source_space_i;
  logic [63:0] address_i;
  logic [63:0] length_i;
  logic [4:0]  region_bits_i;
  logic        done_o;
  logic [1:0]  status_o;

  // region pool mirror
  int unsigned pool_used;
  logic [63:0] pool_base[vmr_pkg::MaxRegions];
  logic [63:0] pool_limit[vmr_pkg::MaxRegions];
  logic [4:0]  pool_flags[vmr_pkg::MaxRegions];
  logic [2:0]  pool_space[vmr_pkg::MaxRegions];

  status_board board;
  longint cycles;
  bit timed_out;

  vm_region_table_cow_fault_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .func_i(func_i), .space_i(space_i), .source_space_i(source_space_i),
    .address_i(address_i), .length_i(length_i), .region_bits_i(region_bits_i),
    .done_o(done_o), .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [1:0] append_region(logic [2:0] sp, logic [63:0] base,
                                               logic [63:0] len, logic [4:0] flags);
    if (len == 64'd0 || pool_used >= vmr_pkg::MaxRegions) return vmr_pkg::StInvalid;
    pool_base[pool_used] = base;
    pool_limit[pool_used] = base + len;
    pool_flags[pool_used] = flags;
    pool_space[pool_used] = sp;
    pool_used++;
    return vmr_pkg::StOk;
  endfunction

  function automatic logic [1:0] predict_status(logic [1:0] fn, logic [2:0] sp,
                                                logic [2:0] src, logic [63:0] addr,
                                                logic [63:0] len, logic [4:0] flags);
    int i;
    logic [4:0] f;
    logic [1:0] dummy;
    if (fn == vmr_pkg::FuncMap) return append_region(sp, addr, len, flags);
    if (fn == vmr_pkg::FuncFork) begin
      for (i = int'(pool_used) - 1; i >= 0; i--) begin
        if (pool_space[i] == src) begin
          f = pool_flags[i];
          if (f[vmr_pkg::FlWrite]) begin
            f[vmr_pkg::FlWrite] = 1'b0;
            f[vmr_pkg::FlCow] = 1'b1;
          end
          dummy = append_region(sp, pool_base[i], pool_limit[i] - pool_base[i], f);
        end
      end
      return vmr_pkg::StOk;
    end
    if (fn == vmr_pkg::FuncFault) begin
      for (i = int'(pool_used) - 1; i >= 0; i--) begin
        if (pool_space[i] == sp && addr >= pool_base[i] && addr < pool_limit[i]) begin
          f = pool_flags[i];
          if (f[vmr_pkg::FlGuard]) return vmr_pkg::StGuard;
          if (f[vmr_pkg::FlDemand]) return vmr_pkg::StOk;
          if (f[vmr_pkg::FlCow]) begin
            f[vmr_pkg::FlWrite] = 1'b1;
            f[vmr_pkg::FlCow] = 1'b0;
            pool_flags[i] = f;
          end
          return vmr_pkg::StOk;
        end
      end
      return vmr_pkg::StNotFound;
    end
    return vmr_pkg::StInvalid;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_request(logic [1:0] fn, logic [2:0] sp, logic [2:0] src,
                              logic [63:0] addr, logic [63:0] len, logic [4:0] flags);
    start <= 1'b1;
    func_i <= fn;
    space_i <= sp;
    source_space_i <= src;
    address_i <= addr;
    length_i <= len;
    region_bits_i <= flags;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_request(predict_status(fn, sp, src, addr, len, flags));
    idle_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending_status.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // addresses mostly from three small windows so lookups hit often
  function automatic logic [63:0] near_addr();
    logic [63:0] b;
    case ($urandom_range(0, 3))
      0: b = 64'h0;
      1: b = 64'h0000_7fff_0000_0000;
      2: b = 64'hffff_ffff_ffff_f000;
      default: return rand64();
    endcase
    return b + $urandom_range(0, 4095);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_status(status_o);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000 && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL vm_region_table_cow_fault_top");
      $finish;
    end
  end

  initial begin
    int k;
    int r;
    logic [1:0] fn;
    board = new();
    pool_used = 0;
    cycles = 0;
    timed_out = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = vmr_pkg::FuncMap;
    space_i = '0;
    source_space_i = '0;
    address_i = '0;
    length_i = '0;
    region_bits_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_request(vmr_pkg::FuncFault, 3'd0, 3'd0, 64'h0, 64'h0, 5'h0);
    send_request(vmr_pkg::FuncMap, 3'd0, 3'd0, 64'h1000, 64'h0, 5'h1f);
    send_request(vmr_pkg::FuncMap, 3'd0, 3'd0, 64'h1000, 64'h1000, 5'h03);
    send_request(vmr_pkg::FuncMap, 3'd1, 3'd7, 64'hffff_ffff_ffff_ffff,
                 64'hffff_ffff_ffff_ffff, 5'h00);
    send_request(vmr_pkg::FuncMap, 3'd7, 3'd0, 64'h0, 64'h100, 5'h04);
    send_request(vmr_pkg::FuncMap, 3'd7, 3'd0, 64'h200, 64'h100, 5'h08);
    send_request(vmr_pkg::FuncMap, 3'd0, 3'd0, 64'hffff_ffff_ffff_ff00, 64'h200, 5'h03);
    send_request(vmr_pkg::FuncFault, 3'd0, 3'd0, 64'h1fff, 64'h0, 5'h0);
    send_request(vmr_pkg::FuncFault, 3'd0, 3'd0, 64'h2000, 64'h0, 5'h0);
    send_request(vmr_pkg::FuncFault, 3'd0, 3'd0, 64'hffff_ffff_ffff_ff80, 64'h0, 5'h0);
    send_request(vmr_pkg::FuncFault, 3'd7, 3'd0, 64'h0, 64'h0, 5'h0);
    send_request(vmr_pkg::FuncFault, 3'd7, 3'd0, 64'h2ff, 64'h0, 5'h0);
    send_request(vmr_pkg::FuncFork, 3'd2, 3'd0, 64'h0, 64'h0, 5'h0);
    send_request(vmr_pkg::FuncFault, 3'd2, 3'd0, 64'h1800, 64'h0, 5'h0);
    send_request(vmr_pkg::FuncFault, 3'd2, 3'd0, 64'h1800, 64'h0, 5'h0);
    send_request(vmr_pkg::FuncFork, 3'd7, 3'd7, 64'h0, 64'h0, 5'h0);
    send_request(2'd3, 3'd5, 3'd5, rand64(), rand64(), 5'h1f);
    send_request(vmr_pkg::FuncFault, 3'd4, 3'd0, 64'hffff_ffff_ffff_ffff, 64'h0, 5'h0);
    drain();

    // random, in episodes; pool fills so resets of the mirror are not possible,
    // so the pool simply saturates and map then returns invalid
    for (k = 0; k < 850; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) fn = vmr_pkg::FuncMap;
      else if (r < 50) fn = vmr_pkg::FuncFork;
      else if (r < 97) fn = vmr_pkg::FuncFault;
      else fn = 2'd3;
      send_request(fn, 3'($urandom_range(0, 7)),
                   ($urandom_range(0, 1) ? 3'($urandom_range(0, 2)) : 3'($urandom)),
                   (fn == vmr_pkg::FuncMap || $urandom_range(0, 3) != 0) ? near_addr()
                                                                         : rand64(),
                   ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 64'd0 : rand64())
                                                : 64'($urandom_range(1, 2048)),
                   5'($urandom));
      if (k == 400) drain();
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending_status.size() == 0) begin
      $display("PASS vm_region_table_cow_fault_top");
    end else begin
      $display("FAIL vm_region_table_cow_fault_top");
    end
    $finish;
  end

endmodule
